>>> design/hsjt_pkg.sv
// ----------------------------------------------------------------------------
// hsjt_pkg
// Shared widths, codes and types of the Hermite spline trajectory evaluator.
// ----------------------------------------------------------------------------
package hsjt_pkg;

    // Field widths of the streams and registers.
    localparam int NODE_IDX_W  = 5;
    localparam int JOINT_NUM_W = 4;
    localparam int JOINT_ID_W  = 4;
    localparam int DATA_W      = 32;
    localparam int NN_W        = 6;
    localparam int LEN_W       = 21;
    localparam int INV_W       = 32;
    localparam int HALF_W      = 16;
    localparam int CFG_IDX_W   = 2;

    localparam int S_TDATA_W   = 112;
    localparam int M_TDATA_W   = 72;

    // Fraction s and its powers are unsigned Q1.16 in [0, 1].
    localparam int FRAC_W      = 17;
    localparam logic [FRAC_W-1:0] ONE_Q = 17'd65536;

    // Basis weights are signed Q4.16 within about six times one.
    localparam int BASIS_W     = 21;

    localparam int KNOT_W      = 2 * DATA_W;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_EVAL  = 1'b1
    } hsjt_op_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_NODES   = 2'd0,
        CFG_SEG_LEN     = 2'd1,
        CFG_INV_SEG_LEN = 2'd2
    } hsjt_cfg_t;

    // One knot entry of one joint.
    typedef struct packed {
        logic signed [DATA_W-1:0] vel;
        logic signed [DATA_W-1:0] pos;
    } hsjt_knot_t;

    // Per-evaluation constants handed from the setup unit to the joint pipeline.
    typedef struct packed {
        logic signed [BASIS_W-1:0] h0;
        logic signed [BASIS_W-1:0] h1;
        logic signed [BASIS_W-1:0] h2;
        logic signed [BASIS_W-1:0] h3;
        logic signed [BASIS_W-1:0] d0;
        logic signed [BASIS_W-1:0] d1;
        logic signed [BASIS_W-1:0] d2;
        logic signed [BASIS_W-1:0] d3;
        logic [LEN_W-1:0]          len;
        logic [HALF_W-1:0]         inv_hi;
        logic [HALF_W-1:0]         inv_lo;
    } hsjt_coef_t;

endpackage

>>> design/hsjt_knot_ram.sv
// ----------------------------------------------------------------------------
// hsjt_knot_ram
// Knot table: one write port and two read ports with registered read data.
// ----------------------------------------------------------------------------
module hsjt_knot_ram #(
    parameter int DEPTH  = 512,
    parameter int AW     = 9,
    parameter int DW     = 64
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          rd_en,
    input  logic [AW-1:0] raddr_a,
    input  logic [AW-1:0] raddr_b,
    output logic [DW-1:0] rdata_a,
    output logic [DW-1:0] rdata_b
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_a_reg;
    logic [DW-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Read data holds while the consumer is stalled.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

>>> design/hsjt_setup.sv
// ----------------------------------------------------------------------------
// hsjt_setup
// Clamps the time, finds the segment by iterative division and computes the
// local fraction and the Hermite basis weights for one evaluation.
// ----------------------------------------------------------------------------
module hsjt_setup #(
    parameter int MAX_NODES = 32,
    parameter int JOINTS    = 16,
    parameter int AW        = 9
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [hsjt_pkg::DATA_W-1:0] eval_time,
    input  logic [hsjt_pkg::NN_W-1:0]   num_nodes,
    input  logic [hsjt_pkg::LEN_W-1:0]  seg_len,
    input  logic [hsjt_pkg::INV_W-1:0]  inv_seg_len,
    output logic                        done,
    output hsjt_pkg::hsjt_coef_t        coef,
    output logic [AW-1:0]               base_a,
    output logic [AW-1:0]               base_b
);

    localparam int LEN_W   = hsjt_pkg::LEN_W;
    localparam int FRAC_W  = hsjt_pkg::FRAC_W;
    localparam int BASIS_W = hsjt_pkg::BASIS_W;
    localparam int NW      = $clog2(MAX_NODES);
    localparam int NCW     = $clog2(MAX_NODES + 1);
    localparam int HOR_W   = LEN_W + NW;
    localparam int BIT_W   = (NW > 1) ? $clog2(NW) : 1;
    localparam int FPROD_W = LEN_W + hsjt_pkg::INV_W;
    localparam int SQ_W    = 2 * FRAC_W;

    localparam logic signed [BASIS_W-1:0] B_ONE = 21'sd65536;

    typedef enum logic [9:0] {
        SU_IDLE  = 10'b0000000001,
        SU_HOR   = 10'b0000000010,
        SU_CLAMP = 10'b0000000100,
        SU_DIV   = 10'b0000001000,
        SU_SEG   = 10'b0000010000,
        SU_FRAC  = 10'b0000100000,
        SU_SCALE = 10'b0001000000,
        SU_SQ    = 10'b0010000000,
        SU_CUBE  = 10'b0100000000,
        SU_BASIS = 10'b1000000000
    } su_state_t;

    su_state_t             state_reg, state_next;
    logic [BIT_W-1:0]      bit_reg;
    logic                  done_reg;

    logic [NW-1:0]         nodes_m1_reg;
    logic [LEN_W-1:0]      len_reg;
    logic [hsjt_pkg::INV_W-1:0] inv_reg;
    logic [hsjt_pkg::DATA_W-1:0] time_reg;
    logic [HOR_W-1:0]      horizon_reg;
    logic [HOR_W-1:0]      rem_reg;
    logic [NW-1:0]         quo_reg;
    logic [LEN_W-1:0]      r_reg;
    logic [FPROD_W-1:0]    frac_reg;
    logic [FRAC_W-1:0]     s_reg;
    logic [FRAC_W-1:0]     s2_reg;
    logic [FRAC_W-1:0]     s3_reg;
    logic [AW-1:0]         base_a_reg;
    logic [AW-1:0]         base_b_reg;
    hsjt_pkg::hsjt_coef_t  coef_reg;

    logic [NCW-1:0]        nodes_eff;
    logic [LEN_W-1:0]      len_eff;
    logic [HOR_W-1:0]      dshift;
    logic [HOR_W:0]        trial;
    logic                  seg_last;
    logic [NW-1:0]         k_sel;
    logic [LEN_W-1:0]      r_sel;
    logic [FPROD_W:0]      frac_rnd;
    logic [FPROD_W-16:0]   s_raw;
    logic [FRAC_W-1:0]     s_next;
    logic [SQ_W:0]         sq_rnd;
    logic [SQ_W:0]         cube_rnd;
    logic signed [BASIS_W-1:0] bs, bs2, bs3;
    hsjt_pkg::hsjt_coef_t  coef_next;

    // Effective knot count and segment length at the start of an evaluation.
    always_comb begin
        if (num_nodes < hsjt_pkg::NN_W'(2)) begin
            nodes_eff = NCW'(2);
        end else if (int'(num_nodes) > MAX_NODES) begin
            nodes_eff = NCW'(MAX_NODES);
        end else begin
            nodes_eff = NCW'(num_nodes);
        end
        len_eff = (seg_len == '0) ? LEN_W'(1) : seg_len;
    end

    // One restoring division step per cycle, most significant quotient bit first.
    always_comb begin
        dshift   = HOR_W'(len_reg) << bit_reg;
        trial    = {1'b0, rem_reg} - {1'b0, dshift};
        // The quotient reaches the last knot only at the end of the horizon.
        seg_last = (quo_reg >= nodes_m1_reg);
        k_sel    = seg_last ? (nodes_m1_reg - NW'(1)) : quo_reg;
        r_sel    = seg_last ? (rem_reg[LEN_W-1:0] + len_reg) : rem_reg[LEN_W-1:0];
        frac_rnd = (FPROD_W + 1)'(frac_reg) + (FPROD_W + 1)'(32768);
        s_raw    = frac_rnd[FPROD_W:16];
        s_next   = (s_raw > (FPROD_W - 15)'(ONE_FULL())) ? hsjt_pkg::ONE_Q
                                                         : FRAC_W'(s_raw);
        sq_rnd   = (SQ_W + 1)'(SQ_W'(s_reg) * SQ_W'(s_reg)) + (SQ_W + 1)'(32768);
        cube_rnd = (SQ_W + 1)'(SQ_W'(s2_reg) * SQ_W'(s_reg)) + (SQ_W + 1)'(32768);
    end

    function automatic logic [FRAC_W-1:0] ONE_FULL();
        return hsjt_pkg::ONE_Q;
    endfunction

    // Cubic Hermite basis and its derivative with respect to s.
    always_comb begin
        bs  = BASIS_W'(s_reg);
        bs2 = BASIS_W'(s2_reg);
        bs3 = BASIS_W'(s3_reg);
        coef_next        = coef_reg;
        coef_next.h0     = (bs3 <<< 1) - (bs2 <<< 1) - bs2 + B_ONE;
        coef_next.h1     = bs3 - (bs2 <<< 1) + bs;
        coef_next.h2     = (bs2 <<< 1) + bs2 - (bs3 <<< 1);
        coef_next.h3     = bs3 - bs2;
        coef_next.d0     = (bs2 <<< 2) + (bs2 <<< 1) - (bs <<< 2) - (bs <<< 1);
        coef_next.d1     = (bs2 <<< 1) + bs2 - (bs <<< 2) + B_ONE;
        coef_next.d2     = (bs <<< 2) + (bs <<< 1) - (bs2 <<< 2) - (bs2 <<< 1);
        coef_next.d3     = (bs2 <<< 1) + bs2 - (bs <<< 1);
        coef_next.len    = len_reg;
        coef_next.inv_hi = inv_reg[31:16];
        coef_next.inv_lo = inv_reg[15:0];
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            SU_IDLE:  if (start) state_next = SU_HOR;
            SU_HOR:   state_next = SU_CLAMP;
            SU_CLAMP: state_next = SU_DIV;
            SU_DIV:   if (bit_reg == '0) state_next = SU_SEG;
            SU_SEG:   state_next = SU_FRAC;
            SU_FRAC:  state_next = SU_SCALE;
            SU_SCALE: state_next = SU_SQ;
            SU_SQ:    state_next = SU_CUBE;
            SU_CUBE:  state_next = SU_BASIS;
            SU_BASIS: state_next = SU_IDLE;
            default:  state_next = SU_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SU_IDLE;
            bit_reg   <= '0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= (state_reg == SU_BASIS);
            if (state_reg == SU_CLAMP) begin
                bit_reg <= BIT_W'(NW - 1);
            end else if (state_reg == SU_DIV) begin
                bit_reg <= bit_reg - BIT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            SU_IDLE: begin
                nodes_m1_reg <= NW'(nodes_eff - NCW'(1));
                len_reg      <= len_eff;
                inv_reg      <= inv_seg_len;
                time_reg     <= eval_time;
            end
            SU_HOR: begin
                horizon_reg <= HOR_W'(len_reg) * HOR_W'(nodes_m1_reg);
            end
            SU_CLAMP: begin
                rem_reg <= (time_reg > hsjt_pkg::DATA_W'(horizon_reg)) ? horizon_reg
                                                                       : HOR_W'(time_reg);
                quo_reg <= '0;
            end
            SU_DIV: begin
                if (!trial[HOR_W]) begin
                    rem_reg          <= trial[HOR_W-1:0];
                    quo_reg[bit_reg] <= 1'b1;
                end
            end
            SU_SEG: begin
                r_reg      <= r_sel;
                base_a_reg <= AW'(k_sel) * AW'(JOINTS);
            end
            SU_FRAC: begin
                frac_reg   <= FPROD_W'(r_reg) * FPROD_W'(inv_reg);
                base_b_reg <= base_a_reg + AW'(JOINTS);
            end
            SU_SCALE: s_reg    <= s_next;
            SU_SQ:    s2_reg   <= sq_rnd[16 +: FRAC_W];
            SU_CUBE:  s3_reg   <= cube_rnd[16 +: FRAC_W];
            SU_BASIS: coef_reg <= coef_next;
            default:  ;
        endcase
    end

    assign done   = done_reg;
    assign coef   = coef_reg;
    assign base_a = base_a_reg;
    assign base_b = base_b_reg;

endmodule

>>> design/hsjt_joint_pipe.sv
// ----------------------------------------------------------------------------
// hsjt_joint_pipe
// Per-joint datapath: weights the two knot entries with the basis, scales the
// slope terms and saturates. Every stage advances together on adv.
// ----------------------------------------------------------------------------
module hsjt_joint_pipe (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               adv,
    input  logic                               in_valid,
    input  logic [hsjt_pkg::JOINT_ID_W-1:0]    in_joint,
    input  logic                               in_last,
    input  hsjt_pkg::hsjt_knot_t               knot_a,
    input  hsjt_pkg::hsjt_knot_t               knot_b,
    input  hsjt_pkg::hsjt_coef_t               coef,
    output logic                               out_valid,
    output logic [hsjt_pkg::JOINT_ID_W-1:0]    out_joint,
    output logic signed [hsjt_pkg::DATA_W-1:0] out_pos,
    output logic signed [hsjt_pkg::DATA_W-1:0] out_vel,
    output logic                               out_last,
    output logic                               busy
);

    localparam int DATA_W = hsjt_pkg::DATA_W;
    localparam int JW     = hsjt_pkg::JOINT_ID_W;
    localparam int PROD_W = hsjt_pkg::BASIS_W + DATA_W;      // basis times knot value
    localparam int SUM_W  = PROD_W + 1;
    localparam int NAR_W  = 34;                              // rounded partial sums
    localparam int LVP_W  = hsjt_pkg::LEN_W + 1 + NAR_W;     // length times slope part
    localparam int DIV_W  = NAR_W + hsjt_pkg::HALF_W + 1;    // dif times half of inverse
    localparam int POS_W  = LVP_W + 1;
    localparam int VEL_W  = DIV_W + 2;

    localparam logic signed [SUM_W-1:0] HALF_S = 54'sd32768;
    localparam logic signed [POS_W-1:0] HALF_P = 57'sd32768;
    localparam logic signed [DIV_W-1:0] HALF_D = 51'sd32768;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) begin
            return 32'sh7FFFFFFF;
        end else if (x < -64'sd2147483648) begin
            return 32'sh80000000;
        end
        return DATA_W'(x);
    endfunction

    // Stage A: products.
    logic                    pa_valid_reg;
    logic [JW-1:0]           pa_joint_reg;
    logic                    pa_last_reg;
    logic signed [PROD_W-1:0] h0q0_reg, h2q1_reg, h1v0_reg, h3v1_reg;
    logic signed [PROD_W-1:0] d0q0_reg, d2q1_reg, d1v0_reg, d3v1_reg;

    // Stage B: rounded sums.
    logic                    pb_valid_reg;
    logic [JW-1:0]           pb_joint_reg;
    logic                    pb_last_reg;
    logic signed [SUM_W-1:0] psum_reg;
    logic signed [NAR_W-1:0] vpart_reg, dif_reg, vvel_reg;

    // Stage C: scaling products.
    logic                    pc_valid_reg;
    logic [JW-1:0]           pc_joint_reg;
    logic                    pc_last_reg;
    logic signed [SUM_W-1:0] psum_c_reg;
    logic signed [NAR_W-1:0] vvel_c_reg;
    logic signed [LVP_W-1:0] lvp_reg;
    logic signed [DIV_W-1:0] dhi_reg, dlo_reg;

    // Output stage.
    logic                    out_valid_reg;
    logic [JW-1:0]           out_joint_reg;
    logic                    out_last_reg;
    logic signed [DATA_W-1:0] out_pos_reg, out_vel_reg;

    logic signed [SUM_W-1:0] vsum, dsum, wsum;
    logic signed [POS_W-1:0] pos_sum;
    logic signed [DIV_W-1:0] lo_sum;
    logic signed [VEL_W-1:0] vel_sum;

    always_comb begin
        vsum    = SUM_W'(h1v0_reg) + SUM_W'(h3v1_reg) + HALF_S;
        dsum    = SUM_W'(d0q0_reg) + SUM_W'(d2q1_reg) + HALF_S;
        wsum    = SUM_W'(d1v0_reg) + SUM_W'(d3v1_reg) + HALF_S;
        pos_sum = POS_W'(psum_c_reg) + POS_W'(lvp_reg) + HALF_P;
        lo_sum  = dlo_reg + HALF_D;
        vel_sum = VEL_W'(dhi_reg) + VEL_W'($signed(lo_sum[DIV_W-1:16]))
                + VEL_W'(vvel_c_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pa_valid_reg  <= 1'b0;
            pb_valid_reg  <= 1'b0;
            pc_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            pa_valid_reg  <= in_valid;
            pb_valid_reg  <= pa_valid_reg;
            pc_valid_reg  <= pb_valid_reg;
            out_valid_reg <= pc_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            pa_joint_reg <= in_joint;
            pa_last_reg  <= in_last;
            h0q0_reg <= PROD_W'(coef.h0) * PROD_W'(knot_a.pos);
            h2q1_reg <= PROD_W'(coef.h2) * PROD_W'(knot_b.pos);
            h1v0_reg <= PROD_W'(coef.h1) * PROD_W'(knot_a.vel);
            h3v1_reg <= PROD_W'(coef.h3) * PROD_W'(knot_b.vel);
            d0q0_reg <= PROD_W'(coef.d0) * PROD_W'(knot_a.pos);
            d2q1_reg <= PROD_W'(coef.d2) * PROD_W'(knot_b.pos);
            d1v0_reg <= PROD_W'(coef.d1) * PROD_W'(knot_a.vel);
            d3v1_reg <= PROD_W'(coef.d3) * PROD_W'(knot_b.vel);

            pb_joint_reg <= pa_joint_reg;
            pb_last_reg  <= pa_last_reg;
            psum_reg     <= SUM_W'(h0q0_reg) + SUM_W'(h2q1_reg);
            vpart_reg    <= $signed(vsum[16 +: NAR_W]);
            dif_reg      <= $signed(dsum[16 +: NAR_W]);
            vvel_reg     <= $signed(wsum[16 +: NAR_W]);

            pc_joint_reg <= pb_joint_reg;
            pc_last_reg  <= pb_last_reg;
            psum_c_reg   <= psum_reg;
            vvel_c_reg   <= vvel_reg;
            lvp_reg      <= LVP_W'($signed({1'b0, coef.len})) * LVP_W'(vpart_reg);
            dhi_reg      <= DIV_W'(dif_reg) * DIV_W'($signed({1'b0, coef.inv_hi}));
            dlo_reg      <= DIV_W'(dif_reg) * DIV_W'($signed({1'b0, coef.inv_lo}));

            out_joint_reg <= pc_joint_reg;
            out_last_reg  <= pc_last_reg;
            out_pos_reg   <= sat32(64'($signed(pos_sum[POS_W-1:16])));
            out_vel_reg   <= sat32(64'(vel_sum));
        end
    end

    assign out_valid = out_valid_reg;
    assign out_joint = out_joint_reg;
    assign out_last  = out_last_reg;
    assign out_pos   = out_pos_reg;
    assign out_vel   = out_vel_reg;
    assign busy      = pa_valid_reg | pb_valid_reg | pc_valid_reg | out_valid_reg;

endmodule

>>> design/hermite_spline_joint_trajectory.sv
// ----------------------------------------------------------------------------
// hermite_spline_joint_trajectory
// Cubic Hermite spline evaluator over a knot table of joint positions and
// velocities, Q16.16 fixed point, with saturated results.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake           Carries
//  s_*       in         s_tvalid/s_tready   one knot write or one evaluate request
//  m_*       out        m_tvalid/m_tready   one joint result, m_tlast on the final joint
//  cfg_*     in         cfg_valid/cfg_ready register index and data, always ready
//
//  A knot write is stored in the cycle it is accepted.
//  An evaluate request first runs the segment search, which divides one quotient
//  bit per cycle; then, while the result side does not stall, the knot table's two
//  read ports deliver one joint per cycle into the multiply pipeline.
//  A low m_tready while a result waits freezes the whole joint pipeline, including the table reads.
//  Reset is synchronous and active low; the knot table needs no clearing.
//
module hermite_spline_joint_trajectory #(
    parameter int MAX_NODES = 32,
    parameter int JOINTS    = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,

    input  logic                              s_tvalid,
    output logic                              s_tready,
    // s_tdata, from bit 0 up: node_index[4:0], joint_number[8:5],
    // node_position[40:9], node_velocity[72:41], eval_time[104:73], zero pad.
    input  logic [hsjt_pkg::S_TDATA_W-1:0]    s_tdata,
    // s_tuser: opcode (0 write knot entry, 1 evaluate).
    input  logic                              s_tuser,

    output logic                              m_tvalid,
    input  logic                              m_tready,
    // m_tdata, from bit 0 up: joint_id[3:0], desired_position[35:4],
    // desired_velocity[67:36], zero pad.
    output logic [hsjt_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tlast,

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [hsjt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [hsjt_pkg::DATA_W-1:0]       cfg_data
);

    localparam int DEPTH = MAX_NODES * JOINTS;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int JCW   = (JOINTS > 1) ? $clog2(JOINTS) : 1;
    localparam int JW    = hsjt_pkg::JOINT_ID_W;
    localparam int PAD_W = hsjt_pkg::M_TDATA_W - JW - 2 * hsjt_pkg::DATA_W;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SETUP = 4'b0010,
        ST_RUN   = 4'b0100,
        ST_DRAIN = 4'b1000
    } state_t;

    // Control state and configuration registers.
    state_t                           state_reg, state_next;
    logic [JCW-1:0]                   joint_cnt_reg;
    logic                             rd_valid_reg;
    logic [JW-1:0]                    rd_joint_reg;
    logic                             rd_last_reg;
    logic [hsjt_pkg::NN_W-1:0]        num_nodes_reg;
    logic [hsjt_pkg::LEN_W-1:0]       seg_len_reg;
    logic [hsjt_pkg::INV_W-1:0]       inv_len_reg;

    // Unpacked input fields.
    hsjt_pkg::hsjt_op_t               opcode;
    logic [hsjt_pkg::NODE_IDX_W-1:0]  node_index;
    logic [hsjt_pkg::JOINT_NUM_W-1:0] joint_number;
    logic [hsjt_pkg::DATA_W-1:0]      node_position;
    logic [hsjt_pkg::DATA_W-1:0]      node_velocity;
    logic [hsjt_pkg::DATA_W-1:0]      eval_time;

    logic                             s_xfer;
    logic                             eval_start;
    logic                             knot_we;
    logic [AW-1:0]                    knot_waddr;
    hsjt_pkg::hsjt_knot_t             knot_wdata;
    logic                             adv;
    logic                             issue;
    logic                             last_issue;
    logic [AW-1:0]                    raddr_a;
    logic [AW-1:0]                    raddr_b;
    logic [hsjt_pkg::KNOT_W-1:0]      rdata_a;
    logic [hsjt_pkg::KNOT_W-1:0]      rdata_b;

    logic                             setup_done;
    hsjt_pkg::hsjt_coef_t             coef;
    logic [AW-1:0]                    base_a;
    logic [AW-1:0]                    base_b;

    logic                             out_valid;
    logic [JW-1:0]                    out_joint;
    logic signed [hsjt_pkg::DATA_W-1:0] out_pos;
    logic signed [hsjt_pkg::DATA_W-1:0] out_vel;
    logic                             out_last;
    logic                             pipe_busy;

    // Field extraction from the input transaction.
    assign opcode        = hsjt_pkg::hsjt_op_t'(s_tuser);
    assign node_index    = s_tdata[4:0];
    assign joint_number  = s_tdata[8:5];
    assign node_position = s_tdata[40:9];
    assign node_velocity = s_tdata[72:41];
    assign eval_time     = s_tdata[104:73];

    // Requests are taken one at a time; a knot write completes in the cycle it
    // is accepted, an evaluation holds the channel until its last result leaves.
    assign s_tready   = (state_reg == ST_IDLE);
    assign s_xfer     = s_tvalid & s_tready;
    assign eval_start = s_xfer & (opcode == hsjt_pkg::OP_EVAL);

    // Writes outside the table are dropped. Knots past num_nodes still store.
    assign knot_we    = s_xfer & (opcode == hsjt_pkg::OP_WRITE)
                      & (int'(node_index) < MAX_NODES)
                      & (int'(joint_number) < JOINTS);
    assign knot_waddr = AW'(node_index) * AW'(JOINTS) + AW'(joint_number);
    assign knot_wdata = '{vel: node_velocity, pos: node_position};

    // The joint pipeline moves whenever the result register is free or drains.
    assign adv        = ~out_valid | m_tready;
    assign issue      = (state_reg == ST_RUN) & adv;
    assign last_issue = (joint_cnt_reg == JCW'(JOINTS - 1));
    assign raddr_a    = base_a + AW'(joint_cnt_reg);
    assign raddr_b    = base_b + AW'(joint_cnt_reg);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (eval_start) state_next = ST_SETUP;
            ST_SETUP: if (setup_done) state_next = ST_RUN;
            ST_RUN:   if (issue && last_issue) state_next = ST_DRAIN;
            ST_DRAIN: if (!rd_valid_reg && !pipe_busy) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            joint_cnt_reg <= '0;
            rd_valid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_SETUP) begin
                joint_cnt_reg <= '0;
            end else if (issue && !last_issue) begin
                joint_cnt_reg <= joint_cnt_reg + JCW'(1);
            end
            if (adv) begin
                rd_valid_reg <= issue;
            end
        end
    end

    // Joint tag and end marker travel beside the registered table read.
    always_ff @(posedge aclk) begin
        if (adv) begin
            rd_joint_reg <= JW'(joint_cnt_reg);
            rd_last_reg  <= last_issue;
        end
    end

    // Configuration registers. The port never stalls; the fourth index is unused.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_nodes_reg <= hsjt_pkg::NN_W'(2);
            seg_len_reg   <= hsjt_pkg::LEN_W'(65536);
            inv_len_reg   <= hsjt_pkg::INV_W'(65536);
        end else if (cfg_valid && cfg_ready) begin
            unique case (hsjt_pkg::hsjt_cfg_t'(cfg_index))
                hsjt_pkg::CFG_NUM_NODES:   num_nodes_reg <= cfg_data[hsjt_pkg::NN_W-1:0];
                hsjt_pkg::CFG_SEG_LEN:     seg_len_reg   <= cfg_data[hsjt_pkg::LEN_W-1:0];
                hsjt_pkg::CFG_INV_SEG_LEN: inv_len_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    hsjt_knot_ram #(
        .DEPTH (DEPTH),
        .AW    (AW),
        .DW    (hsjt_pkg::KNOT_W)
    ) u_ram (
        .aclk    (aclk),
        .we      (knot_we),
        .waddr   (knot_waddr),
        .wdata   (knot_wdata),
        .rd_en   (adv),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rdata_a),
        .rdata_b (rdata_b)
    );

    hsjt_setup #(
        .MAX_NODES (MAX_NODES),
        .JOINTS    (JOINTS),
        .AW        (AW)
    ) u_setup (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (eval_start),
        .eval_time   (eval_time),
        .num_nodes   (num_nodes_reg),
        .seg_len     (seg_len_reg),
        .inv_seg_len (inv_len_reg),
        .done        (setup_done),
        .coef        (coef),
        .base_a      (base_a),
        .base_b      (base_b)
    );

    hsjt_joint_pipe u_pipe (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (rd_valid_reg),
        .in_joint  (rd_joint_reg),
        .in_last   (rd_last_reg),
        .knot_a    (hsjt_pkg::hsjt_knot_t'(rdata_a)),
        .knot_b    (hsjt_pkg::hsjt_knot_t'(rdata_b)),
        .coef      (coef),
        .out_valid (out_valid),
        .out_joint (out_joint),
        .out_pos   (out_pos),
        .out_vel   (out_vel),
        .out_last  (out_last),
        .busy      (pipe_busy)
    );

    // Result transaction straight from the pipeline's output register.
    assign m_tvalid = out_valid;
    assign m_tlast  = out_last;
    assign m_tdata  = {{PAD_W{1'b0}}, out_vel, out_pos, out_joint};

endmodule

>>> tb/tb_hermite_spline_joint_trajectory.sv
// ----------------------------------------------------------------------------
// tb_hermite_spline_joint_trajectory
// Self-checking testbench for the Hermite spline trajectory evaluator. It
// writes knot entries, sends evaluate requests under several register
// settings, predicts every joint result in Q16.16 with saturation, and checks
// each result transaction while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_hermite_spline_joint_trajectory;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     MAX_NODES     = 32;
    localparam int     JOINTS        = 16;
    localparam longint Q_ONE         = 65536;
    localparam longint SAT_HI        = 64'sd2147483647;
    localparam longint SAT_LO        = -64'sd2147483648;
    // Settling time after the last expected result; leave ample margin.
    localparam int     SETTLE_CYCLES = 64;
    // Cycles without any accepted transaction before the run is declared hung.
    localparam int     STALL_LIMIT   = 3000;
    localparam int     PRINT_LIMIT   = 50;

    // One joint result as it leaves the block.
    typedef struct packed {
        logic [3:0]         joint;
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic               last;
    } joint_sample_t;

    logic                               aclk;
    logic                               aresetn;
    logic                               s_tvalid;
    logic                               s_tready;
    logic [hsjt_pkg::S_TDATA_W-1:0]     s_tdata;
    logic                               s_tuser;
    logic                               m_tvalid;
    logic                               m_tready;
    logic [hsjt_pkg::M_TDATA_W-1:0]     m_tdata;
    logic                               m_tlast;
    logic                               cfg_valid;
    logic                               cfg_ready;
    logic [hsjt_pkg::CFG_IDX_W-1:0]     cfg_index;
    logic [hsjt_pkg::DATA_W-1:0]        cfg_data;

    // Mirror of the knot table and of the registers, updated at acceptance.
    logic signed [31:0] knot_pos [MAX_NODES*JOINTS];
    logic signed [31:0] knot_vel [MAX_NODES*JOINTS];
    bit                 knot_set [MAX_NODES*JOINTS];
    logic [5:0]         nodes_cfg;
    logic [20:0]        seg_len_cfg;
    logic [31:0]        inv_len_cfg;

    joint_sample_t      expected_samples[$];

    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_off_left  = 0;
    int quiet_cycles   = 0;

    hermite_spline_joint_trajectory #(
        .MAX_NODES (MAX_NODES),
        .JOINTS    (JOINTS)
    ) DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Fixed-point helpers and the trajectory predictor.
    // ------------------------------------------------------------------------

    // Round to nearest at the Q16.16 point, ties toward plus infinity.
    function automatic longint rnd16(longint x);
        return (x + 32768) >>> 16;
    endfunction

    function automatic logic signed [31:0] sat32(longint x);
        if (x > SAT_HI) return 32'sh7FFFFFFF;
        if (x < SAT_LO) return 32'sh80000000;
        return x[31:0];
    endfunction

    // The knot count register acts as if clamped to the supported range.
    function automatic longint nodes_in_use();
        longint n;
        n = nodes_cfg;
        if (n < 2) n = 2;
        if (n > MAX_NODES) n = MAX_NODES;
        return n;
    endfunction

    // A zero segment length behaves as the smallest step.
    function automatic longint len_in_use();
        return (seg_len_cfg == 0) ? 1 : longint'(seg_len_cfg);
    endfunction

    function automatic longint span_end();
        return len_in_use() * (nodes_in_use() - 1);
    endfunction

    // Clamp the time to the horizon and find the segment and the time into it.
    // At the very end of the horizon the last segment is used with a full step.
    function automatic void locate(input logic [31:0] t_raw, output longint seg,
                                   output longint offset);
        longint t_clamped;
        t_clamped = t_raw;
        if (t_clamped > span_end()) t_clamped = span_end();
        seg = t_clamped / len_in_use();
        if (seg >= nodes_in_use() - 1) seg = nodes_in_use() - 2;
        offset = t_clamped - seg * len_in_use();
    endfunction

    // Works out the position and velocity of every joint at one time and
    // queues them in joint order, the final joint marked as last.
    function automatic void predict_joint_samples(input logic [31:0] t_raw);
        longint seg, offset, len, inv, frac, f2, f3;
        longint h0, h1, h2, h3, d0, d1, d2, d3, inv_hi, inv_lo;
        longint q0, v0, q1, v1, slope_part, pos, dif, vel;
        joint_sample_t sample;
        locate(t_raw, seg, offset);
        len  = len_in_use();
        inv  = inv_len_cfg;
        frac = (offset * inv + 32768) >> 16;
        if (frac > Q_ONE) frac = Q_ONE;
        f2 = rnd16(frac * frac);
        f3 = rnd16(f2 * frac);
        h0 = 2 * f3 - 3 * f2 + Q_ONE;
        h1 = f3 - 2 * f2 + frac;
        h2 = -2 * f3 + 3 * f2;
        h3 = f3 - f2;
        d0 = 6 * f2 - 6 * frac;
        d1 = 3 * f2 - 4 * frac + Q_ONE;
        d2 = -6 * f2 + 6 * frac;
        d3 = 3 * f2 - 2 * frac;
        inv_hi = inv >> 16;
        inv_lo = inv & 64'hFFFF;
        for (int j = 0; j < JOINTS; j++) begin
            q0 = knot_pos[seg * JOINTS + j];
            v0 = knot_vel[seg * JOINTS + j];
            q1 = knot_pos[(seg + 1) * JOINTS + j];
            v1 = knot_vel[(seg + 1) * JOINTS + j];
            // Tangent terms are scaled by the segment length in seconds.
            slope_part = rnd16(h1 * v0 + h3 * v1);
            pos = rnd16(h0 * q0 + h2 * q1 + len * slope_part);
            // The position derivative is per unit fraction; the reciprocal
            // length turns it into per second, split in halves to stay exact.
            dif = rnd16(d0 * q0 + d2 * q1);
            vel = dif * inv_hi + ((dif * inv_lo + 32768) >>> 16)
                + rnd16(d1 * v0 + d3 * v1);
            sample.joint = j[3:0];
            sample.pos   = sat32(pos);
            sample.vel   = sat32(vel);
            sample.last  = (j == JOINTS - 1);
            expected_samples.push_back(sample);
        end
    endfunction

    // Knot values lean toward the extremes so that saturation is reached often.
    function automatic logic [31:0] random_q16();
        case ($urandom_range(7))
            0:       return 32'h7FFFFFFF;
            1:       return 32'h80000000;
            2:       return 32'h0;
            3:       return $urandom_range(0, 32'h3FFFF) - 32'h20000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] random_eval_time();
        longint span, len, nodes, pick;
        span  = span_end();
        len   = len_in_use();
        nodes = nodes_in_use();
        case ($urandom_range(9))
            0:       pick = 0;
            1:       pick = span;
            2, 3:    pick = $urandom;
            4:       pick = $urandom_range(0, nodes - 1) * len;
            5:       pick = $urandom_range(1, nodes - 1) * len - 1;
            default: pick = $urandom_range(0, span[31:0]);
        endcase
        return pick[31:0];
    endfunction

    // Reciprocal of a segment length in Q16.16, capped to the register width.
    function automatic logic [31:0] matched_inverse(longint len);
        longint recip;
        if (len == 0) len = 1;
        recip = (64'h1_0000_0000 + len / 2) / len;
        if (recip > 64'hFFFF_FFFF) recip = 64'hFFFF_FFFF;
        return recip[31:0];
    endfunction

    // ------------------------------------------------------------------------
    // Mismatch reporting and result checking.
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("ERROR at %0t ns: %s", $realtime, msg);
    endtask

    // Every result transaction is compared with the oldest waiting expectation.
    always @(posedge aclk) begin : result_check
        joint_sample_t     want;
        logic [3:0]        got_joint;
        logic signed [31:0] got_pos;
        logic signed [31:0] got_vel;
        if (aresetn && m_tvalid && m_tready) begin
            got_joint = m_tdata[3:0];
            got_pos   = m_tdata[35:4];
            got_vel   = m_tdata[67:36];
            if (expected_samples.size() == 0) begin
                report_mismatch($sformatf("result for joint %0d with nothing expected",
                                          got_joint));
            end else begin
                want = expected_samples.pop_front();
                if (got_joint !== want.joint)
                    report_mismatch($sformatf("joint id: got %0d, expected %0d",
                                              got_joint, want.joint));
                if (got_pos !== want.pos)
                    report_mismatch($sformatf("joint %0d position: got %0d, expected %0d",
                                              want.joint, got_pos, want.pos));
                if (got_vel !== want.vel)
                    report_mismatch($sformatf("joint %0d velocity: got %0d, expected %0d",
                                              want.joint, got_vel, want.vel));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("joint %0d last flag: got %0b, expected %0b",
                                              want.joint, m_tlast, want.last));
            end
        end
    end

    // The result side: random stalls, or a counted hold-off when one is asked.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off_left > 0) begin
                hold_off_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // A run that accepts nothing on any channel for too long is hung.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("ERROR: no transaction accepted for %0d cycles", STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks.
    // ------------------------------------------------------------------------

    // Offers one input transaction after a random idle gap and holds it until
    // it is taken; the mirror and the expectations change at acceptance.
    task automatic send_item(input hsjt_pkg::hsjt_op_t op, input logic [4:0] node,
                             input logic [3:0] joint, input logic [31:0] q,
                             input logic [31:0] v, input logic [31:0] t_eval);
        int idx;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, t_eval, v, q, joint, node};
        do @(posedge aclk); while (!s_tready);
        if (op == hsjt_pkg::OP_WRITE) begin
            idx = node * JOINTS + joint;
            knot_pos[idx] = q;
            knot_vel[idx] = v;
            knot_set[idx] = 1'b1;
        end else begin
            predict_joint_samples(t_eval);
        end
    endtask

    task automatic write_knot(input int node, input int joint, input logic [31:0] q,
                              input logic [31:0] v);
        send_item(hsjt_pkg::OP_WRITE, node[4:0], joint[3:0], q, v, $urandom);
    endtask

    // Writes any entry of a knot that was never written, so that evaluations
    // only ever read defined entries.
    task automatic fill_knot(input longint node);
        for (int j = 0; j < JOINTS; j++)
            if (!knot_set[node * JOINTS + j])
                write_knot(node, j, random_q16(), random_q16());
    endtask

    // The write fields of an evaluate request carry noise; the block ignores them.
    task automatic evaluate_at(input logic [31:0] t_eval);
        longint seg, offset;
        logic [31:0] noise;
        locate(t_eval, seg, offset);
        fill_knot(seg);
        fill_knot(seg + 1);
        noise = $urandom;
        send_item(hsjt_pkg::OP_EVAL, noise[4:0], noise[8:5], $urandom, $urandom, t_eval);
    endtask

    // Drops the input stream, waits for every expected result, then lets the
    // pipeline run out before anything else is changed.
    task automatic drain_results();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_samples.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_register(input hsjt_pkg::hsjt_cfg_t idx, input logic [31:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            hsjt_pkg::CFG_NUM_NODES:   nodes_cfg   = data[5:0];
            hsjt_pkg::CFG_SEG_LEN:     seg_len_cfg = data[20:0];
            hsjt_pkg::CFG_INV_SEG_LEN: inv_len_cfg = data;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Registers change only once the block has gone quiet.
    task automatic set_config(input logic [31:0] nodes_data, input logic [31:0] len_data,
                              input logic [31:0] inv_data);
        drain_results();
        write_register(hsjt_pkg::CFG_NUM_NODES, nodes_data);
        write_register(hsjt_pkg::CFG_SEG_LEN, len_data);
        write_register(hsjt_pkg::CFG_INV_SEG_LEN, inv_data);
    endtask

    // Random settings; unused upper data bits are random since the block drops them.
    task automatic random_config();
        logic [31:0] noise;
        logic [5:0]  nodes;
        logic [20:0] len;
        logic [31:0] inv;
        case ($urandom_range(7))
            0:       nodes = 6'd32;
            1:       nodes = $urandom_range(0, 1);
            2:       nodes = $urandom_range(33, 63);
            default: nodes = $urandom_range(2, 6);
        endcase
        case ($urandom_range(7))
            0:       len = 21'd65536;
            1:       len = $urandom_range(1, 100);
            2:       len = 21'd1048576;
            3:       len = 21'h1FFFFF;
            default: len = $urandom_range(1, 1048576);
        endcase
        case ($urandom_range(15))
            0:       inv = 32'h0;
            1, 2:    inv = $urandom;
            default: inv = matched_inverse(len);
        endcase
        noise = $urandom;
        set_config({noise[31:6], nodes}, {noise[31:21], len}, inv);
    endtask

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Reset settings: two knots one second apart. Knot values run through the
    // extremes of the field, and the times hit both knots, the middle and a
    // time far past the horizon.
    task automatic test_reset_defaults();
        logic [31:0] extremes [5];
        extremes[0] = 32'h7FFFFFFF;
        extremes[1] = 32'h80000000;
        extremes[2] = 32'h0;
        extremes[3] = 32'hFFFFFFFF;
        extremes[4] = 32'h00010000;
        for (int n = 0; n < 2; n++)
            for (int j = 0; j < JOINTS; j++)
                write_knot(n, j, extremes[(j + n) % 5], extremes[(j + 2 * n + 1) % 5]);
        evaluate_at(32'h0);
        evaluate_at(32'h4000);
        evaluate_at(32'h8000);
        evaluate_at(32'h10000);
        evaluate_at(32'hFFFFFFFF);
    endtask

    // Register extremes: knot counts below and above the supported range, a
    // zero segment length, a zero reciprocal, and the widest values.
    task automatic test_register_extremes();
        set_config(32'd0, 32'd65536, 32'd65536);
        evaluate_at(32'h0000C000);
        evaluate_at(32'h00020000);
        set_config(32'd1, 32'd0, 32'd0);
        evaluate_at(32'h0);
        evaluate_at(32'h1);
        evaluate_at(32'hFFFFFFFF);
        set_config(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
        evaluate_at(32'hFFFFFFFF);
        evaluate_at(32'h1);
        evaluate_at(32'h001FFFFF);
        set_config(32'd32, 32'd1048576, matched_inverse(1048576));
        evaluate_at(32'h00080000);
        evaluate_at(32'h00100000);
        evaluate_at(32'hFFFFFFFF);
    endtask

    // Mostly evaluations at random times, with overwrites of random knots in
    // between, over four idling phases and two settings in each.
    task automatic test_random_traffic();
        int idle_pcts  [4];
        int stall_pcts [4];
        idle_pcts  = '{0, 77, 0, 37};
        stall_pcts = '{0, 0, 77, 37};
        for (int phase = 0; phase < 4; phase++) begin
            send_idle_pct  = idle_pcts[phase];
            recv_stall_pct = stall_pcts[phase];
            repeat (2) begin
                random_config();
                repeat (55) begin
                    if ($urandom_range(4) == 0)
                        write_knot($urandom_range(31), $urandom_range(15),
                                   random_q16(), random_q16());
                    else
                        evaluate_at(random_eval_time());
                end
            end
        end
    endtask

    // The result side holds off for a long stretch while requests keep coming,
    // so the block has to stop taking input. Then the sender waits for every
    // result before it starts again under a second hold-off.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        set_config(32'd4, 32'd65536, 32'd65536);
        for (int n = 0; n < 4; n++) fill_knot(n);
        hold_off_left = 400;
        repeat (12) evaluate_at(random_eval_time());
        drain_results();
        recv_stall_pct = 30;
        hold_off_left  = 200;
        repeat (6) evaluate_at(random_eval_time());
        recv_stall_pct = 0;
    endtask

    initial begin
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tuser     = 1'b0;
        s_tdata     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = hsjt_pkg::CFG_NUM_NODES;
        cfg_data    = '0;
        nodes_cfg   = 6'd2;
        seg_len_cfg = 21'd65536;
        inv_len_cfg = 32'd65536;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_register_extremes();
        test_random_traffic();
        test_backpressure();

        drain_results();
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

>>> hermite_spline_joint_trajectory.f
design/hsjt_pkg.sv
design/hsjt_knot_ram.sv
design/hsjt_setup.sv
design/hsjt_joint_pipe.sv
design/hermite_spline_joint_trajectory.sv
tb/tb_hermite_spline_joint_trajectory.sv
